// ----- rtl/cdrom_toc_reply_builder_unit_defines.svh -----
// assertion macros for the toc reply builder
`ifndef CDROM_TOC_REPLY_BUILDER_UNIT_DEFINES_SVH
`define CDROM_TOC_REPLY_BUILDER_UNIT_DEFINES_SVH

// checked on every edge outside reset
`define TOC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define TOC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cdtoc_pkg.sv -----
package cdtoc_pkg;

  // reply shapes, picked when a request is taken
  typedef enum logic [2:0] {
    KIND_TRK,
    KIND_LEADOUT,
    KIND_SESSION,
    KIND_RAW,
    KIND_REJECT
  } toc_kind_t;

  // capacity to msf conversion sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL75,
    ST_MUL60,
    ST_SPLIT
  } div_state_t;

  localparam logic [7:0] FMT_TRACKS  = 8'd0;
  localparam logic [7:0] FMT_SESSION = 8'd1;
  localparam logic [7:0] FMT_RAW     = 8'd2;

  localparam logic [7:0] TRK_LEADOUT = 8'haa;
  localparam logic [7:0] ADR_CTL     = 8'h14;
  localparam logic [7:0] ADR_CTL_LO  = 8'h16;
  localparam logic [7:0] POINT_A0    = 8'ha0;

  localparam logic [31:0] MSF_OFFSET     = 32'd150;
  localparam logic [7:0]  FRAMES_PER_SEC = 8'd75;
  localparam logic [7:0]  SECS_PER_MIN   = 8'd60;

  // reciprocals, exact for any 32-bit dividend: x / 75 = (x * RECIP_75) >> 38,
  // x / 60 = (x * RECIP_60) >> 37
  localparam logic [31:0] RECIP_75 = 32'd3665038760;
  localparam logic [31:0] RECIP_60 = 32'd2290649225;

  // index of the final byte of each reply
  localparam logic [5:0] FINAL_TRK     = 6'd19;
  localparam logic [5:0] FINAL_LEADOUT = 6'd11;
  localparam logic [5:0] FINAL_SESSION = 6'd11;
  localparam logic [5:0] FINAL_RAW     = 6'd47;
  localparam logic [5:0] FINAL_REJECT  = 6'd0;

  // size of one raw toc entry
  localparam logic [5:0] RAW_ENTRY = 6'd11;

  // one byte of an address field, lba big-endian or 0/min/sec/frame
  function automatic logic [7:0] addr_byte(logic [1:0] k, logic as_msf, logic [31:0] cap,
                                           logic [7:0] mins, logic [5:0] secs,
                                           logic [6:0] frms);
    logic [7:0] b;
    b = '0;
    if (as_msf) begin
      case (k)
        2'd0: b = 8'd0;
        2'd1: b = mins;
        2'd2: b = {2'b00, secs};
        2'd3: b = {1'b0, frms};
        default: b = 8'd0;
      endcase
    end else begin
      case (k)
        2'd0: b = cap[31:24];
        2'd1: b = cap[23:16];
        2'd2: b = cap[15:8];
        2'd3: b = cap[7:0];
        default: b = 8'd0;
      endcase
    end
    return b;
  endfunction

  // reply byte at position idx
  function automatic logic [7:0] toc_byte(toc_kind_t kind, logic as_msf, logic [5:0] idx,
                                          logic [5:0] final_idx, logic [31:0] cap,
                                          logic [7:0] mins, logic [5:0] secs,
                                          logic [6:0] frms);
    logic [5:0] r;
    logic [1:0] e;
    logic [5:0] o;
    logic [7:0] b;
    b = '0;
    // raw entry number and offset within it
    r = idx - 6'd4;
    if (r < RAW_ENTRY) begin
      e = 2'd0;
      o = r;
    end else if (r < 6'(2 * RAW_ENTRY)) begin
      e = 2'd1;
      o = r - RAW_ENTRY;
    end else if (r < 6'(3 * RAW_ENTRY)) begin
      e = 2'd2;
      o = r - 6'(2 * RAW_ENTRY);
    end else begin
      e = 2'd3;
      o = r - 6'(3 * RAW_ENTRY);
    end
    if (kind == KIND_REJECT) begin
      b = 8'd0;
    end else if (idx == 6'd0) begin
      b = 8'd0;
    end else if (idx == 6'd1) begin
      b = {2'b00, final_idx - 6'd1};
    end else if (idx == 6'd2 || idx == 6'd3) begin
      b = 8'd1;
    end else begin
      case (kind)
        KIND_TRK: begin
          case (idx)
            6'd5:  b = ADR_CTL;
            6'd6:  b = 8'd1;
            6'd10: b = as_msf ? 8'd2 : 8'd0;
            6'd13: b = ADR_CTL_LO;
            6'd14: b = TRK_LEADOUT;
            6'd16, 6'd17, 6'd18, 6'd19:
              b = addr_byte(idx[1:0], as_msf, cap, mins, secs, frms);
            default: b = 8'd0;
          endcase
        end
        KIND_LEADOUT: begin
          case (idx)
            6'd5: b = ADR_CTL_LO;
            6'd6: b = TRK_LEADOUT;
            6'd8, 6'd9, 6'd10, 6'd11:
              b = addr_byte(idx[1:0], as_msf, cap, mins, secs, frms);
            default: b = 8'd0;
          endcase
        end
        KIND_RAW: begin
          case (o)
            6'd0: b = 8'd1;
            6'd1: b = ADR_CTL;
            6'd3: b = (e == 2'd3) ? 8'd1 : (POINT_A0 + {6'd0, e});
            6'd8: b = (e < 2'd2) ? 8'd1 : 8'd0;
            default: b = 8'd0;
          endcase
          // lead-out start in the third entry
          if (e == 2'd2 && o >= 6'd7) begin
            b = addr_byte(2'(o - 6'd7), as_msf, cap, mins, secs, frms);
          end
        end
        default: b = 8'd0;
      endcase
    end
    return b;
  endfunction

endpackage

// ----- rtl/cdrom_toc_reply_builder_unit.sv -----
// channel   dir  tdata (low bit up)                          side bits
// s_axis    in   mode[7:0] msf[8] start_track[16:9] pad      -
// m_axis    out  data_byte[7:0]                              tlast=last tuser=rejected
// cfg       in   cfg_wdata = capacity_blocks, written on cfg_we
//
// a reply has 20 or 12 bytes for format 0, 12 for format 1, 48 for format 2,
// one for a rejected request; the output register moves one byte a cycle while
// m_axis is ready, and the next request enters the cycle its last byte leaves
// the request register
// rst (synchronous) clears capacity to 0 and empties both registers
// a capacity write starts an msf conversion (reciprocal multiplies for
// /75 and /60 through one shared 32x32 multiplier); s_axis_tready is low
// during the write cycle and the ST_MUL75, ST_MUL60 and ST_SPLIT states after it
// a stalled m_axis holds the byte in the output register and the request in place
`include "cdrom_toc_reply_builder_unit_defines.svh"

module cdrom_toc_reply_builder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // mode[7:0], msf[8], start_track[16:9], zero[23:17]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // data_byte[7:0]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // rejected[0]
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import cdtoc_pkg::*;

  // configuration and its msf form
  logic [31:0] capacity_blocks;
  logic [7:0]  msf_min;
  logic [5:0]  msf_sec;
  logic [6:0]  msf_frm;

  // reciprocal division: frame count, then seconds, through one multiplier
  div_state_t  div_state, div_state_next;
  logic [31:0] div_work;
  logic [63:0] div_prod;
  logic [63:0] div_mul;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [25:0] div_q75;
  logic [19:0] div_q60;
  logic [6:0]  div_frm;
  logic [5:0]  div_sec;
  logic        div_busy;

  // request register
  logic        req_valid;
  toc_kind_t   req_kind;
  logic        req_msf;
  logic [5:0]  req_cnt;
  logic [5:0]  req_final;

  // output register
  logic        out_valid;
  logic [7:0]  out_data;
  logic        out_last;
  logic        out_rej;

  // input beat decode
  logic [7:0]  in_mode;
  logic        in_msf;
  logic [7:0]  in_trk;
  toc_kind_t   kind_next;
  logic [5:0]  final_next;

  logic        in_acc;
  logic        adv;
  logic        req_done;

  assign in_mode = s_axis_tdata[7:0];
  assign in_msf  = s_axis_tdata[8];
  assign in_trk  = s_axis_tdata[16:9];

  // ---------------- msf conversion ----------------
  always_comb begin
    div_state_next = div_state;
    case (div_state)
      ST_IDLE:  div_state_next = ST_IDLE;
      ST_MUL75: div_state_next = ST_MUL60;
      ST_MUL60: div_state_next = ST_SPLIT;
      ST_SPLIT: div_state_next = ST_IDLE;
      default:  div_state_next = ST_IDLE;
    endcase
    // a new write restarts the conversion
    if (cfg_we) div_state_next = ST_MUL75;
  end

  always_comb begin
    div_busy = 1'b0;
    mul_a    = div_work;
    mul_b    = RECIP_75;
    case (div_state)
      ST_IDLE:  div_busy = 1'b0;
      ST_MUL75: begin
        div_busy = 1'b1;
        mul_a    = div_work;
        mul_b    = RECIP_75;
      end
      ST_MUL60: begin
        div_busy = 1'b1;
        mul_a    = {6'd0, div_q75};
        mul_b    = RECIP_60;
      end
      ST_SPLIT: div_busy = 1'b1;
      default:  div_busy = 1'b0;
    endcase
  end

  // quotients from the registered product, remainders by subtraction
  assign div_mul = {32'd0, mul_a} * {32'd0, mul_b};
  assign div_q75 = div_prod[63:38];
  assign div_q60 = div_prod[56:37];
  assign div_frm = 7'(div_work - ({6'd0, div_q75} * 32'(FRAMES_PER_SEC)));
  assign div_sec = 6'(div_work - ({12'd0, div_q60} * 32'(SECS_PER_MIN)));

  always_ff @(posedge clk) begin
    if (rst) begin
      div_state       <= ST_IDLE;
      capacity_blocks <= '0;
      // msf of block 0 plus offset: 0:02:00
      msf_min         <= 8'd0;
      msf_sec         <= 6'd2;
      msf_frm         <= 7'd0;
    end else begin
      div_state <= div_state_next;
      if (cfg_we) begin
        capacity_blocks <= cfg_wdata;
      end else if (div_state == ST_MUL60) begin
        msf_frm <= div_frm;
      end else if (div_state == ST_SPLIT) begin
        msf_sec <= div_sec;
        msf_min <= div_q60[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      div_work <= cfg_wdata + MSF_OFFSET;
    end else if (div_state == ST_MUL60) begin
      // whole seconds, divided by 60 next
      div_work <= {6'd0, div_q75};
    end
    if (div_busy) begin
      div_prod <= div_mul;
    end
  end

  // ---------------- request decode ----------------
  always_comb begin
    kind_next  = KIND_REJECT;
    final_next = FINAL_REJECT;
    if (in_mode == FMT_TRACKS) begin
      if (in_trk <= 8'd1) begin
        kind_next  = KIND_TRK;
        final_next = FINAL_TRK;
      end else if (in_trk == TRK_LEADOUT) begin
        kind_next  = KIND_LEADOUT;
        final_next = FINAL_LEADOUT;
      end
    end else if (in_mode == FMT_SESSION) begin
      kind_next  = KIND_SESSION;
      final_next = FINAL_SESSION;
    end else if (in_mode == FMT_RAW) begin
      kind_next  = KIND_RAW;
      final_next = FINAL_RAW;
    end
  end

  // ---------------- byte stream ----------------
  // a byte moves from the request register into the output register whenever
  // the output register is empty or being drained this cycle
  assign adv      = req_valid && (!out_valid || m_axis_tready);
  assign req_done = adv && (req_cnt == req_final);
  assign s_axis_tready = !div_busy && !cfg_we && (!req_valid || req_done);
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        req_valid <= 1'b1;
      end else if (req_done) begin
        req_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_kind  <= kind_next;
      req_msf   <= in_msf;
      req_final <= final_next;
      req_cnt   <= '0;
    end else if (adv) begin
      req_cnt <= req_cnt + 6'd1;
    end
    if (adv) begin
      out_data <= toc_byte(req_kind, req_msf, req_cnt, req_final, capacity_blocks,
                           msf_min, msf_sec, msf_frm);
      out_last <= (req_cnt == req_final);
      out_rej  <= (req_kind == KIND_REJECT);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_rej;

  // ---------------- checks ----------------
  `TOC_ASSERT(a_accept_conv_done, (in_acc |-> (div_state == ST_IDLE)), "request taken during msf conversion")
  `TOC_ASSERT(a_cnt_in_range, (req_valid |-> (req_cnt <= req_final)), "byte counter ran past reply end")
  `TOC_ASSERT(a_reject_single, ((m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast), "rejected beat not last")
  `TOC_ASSERT_ALWAYS(a_reset_empty, (rst |=> (!out_valid && !req_valid)), "registers not empty after reset")

endmodule
